// File: rtl/core/lpmrt_pkg.sv
`default_nettype none

package lpmrt_pkg;

    // Table geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int ADDR_W   = 32;
    localparam int IFACE_W  = 4;
    localparam int PFX_W    = 6;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    // Beat widths, padded to whole bytes
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 48;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

    // One stored route; prefix length is computed once at insert time
    typedef struct packed {
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gw;
        logic [IFACE_W-1:0] iface;
        logic [PFX_W-1:0]   len;
    } route_entry_t;

    localparam int ENTRY_W = $bits(route_entry_t);

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } fsm_t;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic              start;
        logic              data_vld;
        logic [ADDR_W-1:0] addr;
    } scan_ctrl_t;

    // Current best match held by the scan unit
    typedef struct packed {
        logic               hit;
        logic [ADDR_W-1:0]  hop;
        logic [IFACE_W-1:0] iface;
        logic [PFX_W-1:0]   len;
    } scan_best_t;

    // Leading ones of a mask, binary search in six steps
    function automatic logic [PFX_W-1:0] leading_ones(input logic [ADDR_W-1:0] m);
        logic [ADDR_W-1:0] v;
        logic [PFX_W-1:0]  n;
        v = m;
        n = '0;
        if (v[31:16] == 16'hFFFF) begin
            n = n + 6'd16;
            v = v << 16;
        end
        if (v[31:24] == 8'hFF) begin
            n = n + 6'd8;
            v = v << 8;
        end
        if (v[31:28] == 4'hF) begin
            n = n + 6'd4;
            v = v << 4;
        end
        if (v[31:30] == 2'b11) begin
            n = n + 6'd2;
            v = v << 2;
        end
        if (v[31]) begin
            n = n + 6'd1;
            v = v << 1;
        end
        if (v[31]) begin
            n = n + 6'd1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/lpmrt_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module lpmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          aclk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic                                          re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic      [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lpmrt_scan.sv
`default_nettype none

// Compare unit: checks one entry per cycle against the lookup address, while data_vld is set
module lpmrt_scan
    import lpmrt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire scan_ctrl_t   ctrl,
    input  wire route_entry_t entry,
    output scan_best_t        best
);
    logic [ADDR_W-1:0] addr_reg;
    logic              addr_zero_reg;
    scan_best_t        best_reg;
    logic              match;
    logic              win;

    // Masked compare; for address zero this is "masked dest is zero"
    always_comb begin
        match = ((addr_reg ^ entry.dest) & entry.mask) == '0;
        if (addr_zero_reg) begin
            win = match && !best_reg.hit;
        end else begin
            win = match && (entry.len > best_reg.len);
        end
    end

    // Best-match tracking; only the hit flag is reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg.hit <= 1'b0;
        end else if (ctrl.start) begin
            best_reg.hit <= 1'b0;
        end else if (ctrl.data_vld && win) begin
            best_reg.hit <= 1'b1;
        end

        // payload of the best match
        if (ctrl.start) begin
            addr_reg       <= ctrl.addr;
            addr_zero_reg  <= (ctrl.addr == '0);
            best_reg.len   <= '0;
            best_reg.hop   <= '0;
            best_reg.iface <= '0;
        end else if (ctrl.data_vld && win) begin
            best_reg.len   <= entry.len;
            best_reg.hop   <= entry.gw;
            best_reg.iface <= entry.iface;
        end
    end

    assign best = best_reg;

endmodule

`default_nettype wire

// File: rtl/core/longest_prefix_match_route_table.sv
`default_nettype none

// Channel  Dir  Width  Fields (low bit up)
// s_axis   in   136    opcode, route_destination, route_mask, route_gateway,
//                      route_interface, lookup_address
// m_axis   out  48     status, next_hop, out_interface, matched_prefix
//
// One operation at a time. Clear and add go straight to the result stage; a
// lookup first walks the route memory through its single read port, the compare
// unit checking one entry per cycle, and then goes to the result stage. That stage
// waits for a free output register; input reopens once it has loaded the result.
// Synchronous active-low reset empties the table (count only, no sweep).
// The result register lets a new beat be accepted while the last result
// still waits for m_axis_tready.
module longest_prefix_match_route_table
    import lpmrt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // opcode[1:0], route_destination[33:2], route_mask[65:34],
    // route_gateway[97:66], route_interface[101:98], lookup_address[133:102]
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // status[2:0], next_hop[34:3], out_interface[38:35], matched_prefix[44:39]
    output logic      [M_DATA_W-1:0] m_axis_tdata
);
    // Input field unpack
    logic [OP_W-1:0]    in_op;
    logic [ADDR_W-1:0]  in_dest;
    logic [ADDR_W-1:0]  in_mask;
    logic [ADDR_W-1:0]  in_gw;
    logic [IFACE_W-1:0] in_iface;
    logic [ADDR_W-1:0]  in_addr;

    assign in_op    = s_axis_tdata[1:0];
    assign in_dest  = s_axis_tdata[33:2];
    assign in_mask  = s_axis_tdata[65:34];
    assign in_gw    = s_axis_tdata[97:66];
    assign in_iface = s_axis_tdata[101:98];
    assign in_addr  = s_axis_tdata[133:102];

    fsm_t               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_hop_reg, res_hop_next;
    logic [IFACE_W-1:0] res_iface_reg, res_iface_next;
    logic [PFX_W-1:0]   res_len_reg, res_len_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               ram_we;
    logic               ram_re;
    route_entry_t       wr_entry;
    logic [ENTRY_W-1:0] rd_word;
    route_entry_t       rd_entry;
    scan_ctrl_t         scan_ctrl;
    scan_best_t         best;

    assign wr_entry = '{dest: in_dest, mask: in_mask, gw: in_gw,
                        iface: in_iface, len: leading_ones(in_mask)};
    assign rd_entry = route_entry_t'(rd_word);

    lpmrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (rd_word)
    );

    lpmrt_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (scan_ctrl),
        .entry   (rd_entry),
        .best    (best)
    );

    assign s_axis_tready = (state_reg == FSM_IDLE);

    // Sequencer: decode, memory walk, result hand-off
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        rd_vld_next     = 1'b0;
        res_status_next = res_status_reg;
        res_hop_next    = res_hop_reg;
        res_iface_next  = res_iface_reg;
        res_len_next    = res_len_reg;
        m_tvalid_next   = m_tvalid_reg && !m_axis_tready;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        scan_ctrl.start    = 1'b0;
        scan_ctrl.data_vld = rd_vld_reg;
        scan_ctrl.addr     = in_addr;

        case (state_reg)
            FSM_IDLE: begin
                if (s_axis_tvalid) begin
                    res_hop_next   = '0;
                    res_iface_next = '0;
                    res_len_next   = '0;
                    state_next     = FSM_DONE;
                    case (in_op)
                        OP_CLEAR: begin
                            count_next      = '0;
                            res_status_next = STAT_CLEARED;
                        end
                        OP_ADD: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                ram_we          = 1'b1;
                                count_next      = count_reg + 1'b1;
                                res_status_next = STAT_ADDED;
                            end
                        end
                        OP_LOOKUP: begin
                            scan_ctrl.start = 1'b1;
                            issue_next      = '0;
                            state_next      = FSM_SCAN;
                        end
                        default: begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                    endcase
                end
            end
            FSM_SCAN: begin
                // issue reads while entries remain; read data comes back registered
                if (issue_reg < count_reg) begin
                    ram_re      = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end else if (!rd_vld_reg) begin
                    state_next = FSM_DONE;
                    if (best.hit) begin
                        res_status_next = STAT_FOUND;
                        res_hop_next    = best.hop;
                        res_iface_next  = best.iface;
                        res_len_next    = best.len;
                    end else begin
                        res_status_next = STAT_NOT_FOUND;
                        res_hop_next    = '0;
                        res_iface_next  = '0;
                        res_len_next    = '0;
                    end
                end
            end
            FSM_DONE: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, res_len_reg, res_iface_reg,
                                     res_hop_reg, res_status_reg};
                    state_next    = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        issue_reg      <= issue_next;
        res_status_reg <= res_status_next;
        res_hop_reg    <= res_hop_next;
        res_iface_reg  <= res_iface_next;
        res_len_reg    <= res_len_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/lpmrt_checker.sv
`default_nettype none

// Port-level checks for the route table
module lpmrt_checker
    import lpmrt_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata
);
    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // One operation in flight: input closes right after a beat is taken
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an operation is in flight");

    // Anything but a hit carries zero payload
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[2:0] != STAT_FOUND) |->
            m_axis_tdata[M_DATA_W-1:3] == '0)
        else $error("nonzero payload on a non-hit result");

    // A hit reports a prefix of at most the address width
    a_hit_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[2:0] == STAT_FOUND) |->
            m_axis_tdata[44:39] <= PFX_W'(ADDR_W))
        else $error("prefix length out of range");

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind longest_prefix_match_route_table lpmrt_checker u_lpmrt_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpmrt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_BEATS = 1750;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 250;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int PRINT_CAP    = 40;

    // opcode 3 carries no operation
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   hop;
        logic [IFACE_W-1:0]  ifc;
        logic [PFX_W-1:0]    pfx;
    } route_result_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   gw;
        logic [IFACE_W-1:0]  ifc;
        logic [ADDR_W-1:0]   addr;
        logic                typed;
        logic [STATUS_W-1:0] typed_status;
    } directed_row_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // opcode, route_destination, route_mask, route_gateway, route_interface,
    // lookup_address, 2 zero pad bits
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // status, next_hop, out_interface, matched_prefix, 3 zero pad bits
    logic [M_DATA_W-1:0] m_axis_tdata;

    longest_prefix_match_route_table DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Route table mirror used for prediction
    logic [ADDR_W-1:0]  route_dest [DEPTH];
    logic [ADDR_W-1:0]  route_mask [DEPTH];
    logic [ADDR_W-1:0]  route_gw   [DEPTH];
    logic [IFACE_W-1:0] route_ifc  [DEPTH];
    int                 route_count = 0;

    route_result_t      pending_routes[$];

    // Typed expectation that travels with the current input beat
    logic                beat_typed        = 1'b0;
    logic [STATUS_W-1:0] beat_typed_status = '0;

    int mismatches    = 0;
    int beats_sent    = 0;
    int beats_in      = 0;
    int results_seen  = 0;
    int hits          = 0;
    int misses        = 0;
    int full_refusals = 0;
    int zero_lookups  = 0;
    int cycles        = 0;
    int burst_left    = 0;

    // Stimulus-side view of the table, for addresses that hit
    logic [ADDR_W-1:0] gen_dest[$];
    logic [ADDR_W-1:0] gen_mask[$];

    directed_row_t plan[$];

    function automatic int mask_prefix_len(input logic [ADDR_W-1:0] m);
        int n;
        n = 0;
        for (int i = ADDR_W - 1; i >= 0; i--) begin
            if (!m[i])
                break;
            n++;
        end
        return n;
    endfunction

    // Apply one operation to the mirror and return its result
    function automatic route_result_t route_table_step(
        input logic [OP_W-1:0]    op,
        input logic [ADDR_W-1:0]  dest,
        input logic [ADDR_W-1:0]  mask,
        input logic [ADDR_W-1:0]  gw,
        input logic [IFACE_W-1:0] ifc,
        input logic [ADDR_W-1:0]  addr
    );
        route_result_t r;
        int            best;
        int            best_len;
        int            len;
        bit            hit;
        r        = '0;
        r.status = STAT_NOT_FOUND;
        best     = 0;
        best_len = 0;
        hit      = 1'b0;
        case (op)
            OP_CLEAR: begin
                route_count = 0;
                r.status    = STAT_CLEARED;
            end
            OP_ADD: begin
                if (route_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    route_dest[route_count] = dest;
                    route_mask[route_count] = mask;
                    route_gw[route_count]   = gw;
                    route_ifc[route_count]  = ifc;
                    route_count++;
                    r.status = STAT_ADDED;
                end
            end
            OP_LOOKUP: begin
                if (addr != '0) begin
                    // strictly longer prefix wins, so ties keep the earlier entry
                    for (int i = 0; i < route_count; i++) begin
                        len = mask_prefix_len(route_mask[i]);
                        if (((addr & route_mask[i]) == (route_dest[i] & route_mask[i]))
                                && len > best_len) begin
                            best_len = len;
                            best     = i;
                        end
                    end
                    hit = (best_len != 0);
                end else begin
                    // zero address: first entry with a zero masked destination
                    for (int i = 0; i < route_count; i++) begin
                        if ((route_dest[i] & route_mask[i]) == '0) begin
                            best = i;
                            hit  = 1'b1;
                            break;
                        end
                    end
                end
                if (hit) begin
                    r.status = STAT_FOUND;
                    r.hop    = route_gw[best];
                    r.ifc    = route_ifc[best];
                    r.pfx    = PFX_W'(mask_prefix_len(route_mask[best]));
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns result %0d: %s got 0x%0h want 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    task automatic plan_row(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] dest,
                            input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] gw,
                            input logic [IFACE_W-1:0] ifc, input logic [ADDR_W-1:0] addr,
                            input logic typed, input logic [STATUS_W-1:0] st);
        directed_row_t row;
        row.op           = op;
        row.dest         = dest;
        row.mask         = mask;
        row.gw           = gw;
        row.ifc          = ifc;
        row.addr         = addr;
        row.typed        = typed;
        row.typed_status = st;
        plan.push_back(row);
    endtask

    // Offer one beat, wait for the handshake, then pace the next one
    task automatic send_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] dest,
                           input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] gw,
                           input logic [IFACE_W-1:0] ifc, input logic [ADDR_W-1:0] addr,
                           input logic typed, input logic [STATUS_W-1:0] st);
        int gap;
        @(negedge aclk);
        s_axis_tvalid     <= 1'b1;
        s_axis_tdata      <= {2'b00, addr, ifc, gw, mask, dest, op};
        beat_typed        <= typed;
        beat_typed_status <= st;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                // long stretch with no gaps
                burst_left = $urandom_range(60, 200);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Receiver: changing stall patterns, plus one long hold-off
    initial begin
        int pat_mode;
        int pat_left;
        int pat_phase;
        int hold_left;
        bit hold_done;
        pat_mode  = 0;
        pat_left  = 0;
        pat_phase = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(20, 120);
                end
                pat_left--;
                pat_phase++;
                case (pat_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (pat_phase % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Result check first, then record the expectation of an accepted beat
    always @(posedge aclk) begin
        route_result_t got;
        route_result_t want;
        route_result_t pred;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.status = m_axis_tdata[2:0];
                got.hop    = m_axis_tdata[34:3];
                got.ifc    = m_axis_tdata[38:35];
                got.pfx    = m_axis_tdata[44:39];
                if (pending_routes.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    ADDR_W'(got.status), '0);
                end else begin
                    want = pending_routes.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", ADDR_W'(got.status),
                                        ADDR_W'(want.status));
                    if (got.hop != want.hop)
                        report_mismatch("next_hop", got.hop, want.hop);
                    if (got.ifc != want.ifc)
                        report_mismatch("out_interface", ADDR_W'(got.ifc),
                                        ADDR_W'(want.ifc));
                    if (got.pfx != want.pfx)
                        report_mismatch("matched_prefix", ADDR_W'(got.pfx),
                                        ADDR_W'(want.pfx));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                beats_in++;
                pred = route_table_step(s_axis_tdata[1:0], s_axis_tdata[33:2],
                                        s_axis_tdata[65:34], s_axis_tdata[97:66],
                                        s_axis_tdata[101:98], s_axis_tdata[133:102]);
                if (beat_typed) begin
                    pred        = '0;
                    pred.status = beat_typed_status;
                end
                pending_routes.push_back(pred);
                if (pred.status == STAT_FOUND)
                    hits++;
                if (s_axis_tdata[1:0] == OP_LOOKUP && pred.status == STAT_NOT_FOUND)
                    misses++;
                if (pred.status == STAT_FULL)
                    full_refusals++;
                if (s_axis_tdata[1:0] == OP_LOOKUP && s_axis_tdata[133:102] == '0)
                    zero_lookups++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_routes.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int                phase;
        int                n_add;
        int                n_look;
        int                kind;
        int                len;
        int                pick;
        bit                fill;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] addr;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, nesting, ties, default route, zero address,
        // non-contiguous mask, clear
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0A00_0001, 1, STAT_NOT_FOUND);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0, 1, STAT_NOT_FOUND);
        plan_row(OP_NOP, '1, '1, '1, '1, '1, 1, STAT_NOT_FOUND);
        plan_row(OP_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0001, 4'h1, 0, 1, STAT_ADDED);
        plan_row(OP_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0002, 4'h2, 0, 1, STAT_ADDED);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0, 1, STAT_NOT_FOUND);
        plan_row(OP_ADD, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'hF, 0, 1, STAT_ADDED);
        plan_row(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0, 0, 1, STAT_ADDED);
        plan_row(OP_ADD, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0102_0304, 4'h3, 0, 1, STAT_ADDED);
        plan_row(OP_ADD, 32'h0A01_FFFF, 32'hFFFF_0000, 32'h1111_1111, 4'h4, 0, 1, STAT_ADDED);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0A01_0203, 0, STAT_FOUND);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0A01_FF00, 0, STAT_FOUND);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0AFF_0000, 0, STAT_FOUND);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0B00_0000, 1, STAT_NOT_FOUND);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, STAT_FOUND);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0, 0, STAT_FOUND);
        plan_row(OP_ADD, 32'h1234_5678, 32'hF0F0_F0F0, 32'hA5A5_A5A5, 4'hA, 0, 1, STAT_ADDED);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h1F3F_5F7F, 0, STAT_FOUND);
        plan_row(OP_CLEAR, 0, 0, 0, 0, 0, 1, STAT_CLEARED);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0A01_0203, 1, STAT_NOT_FOUND);
        plan_row(OP_ADD, 32'h0, 32'h8000_0000, 32'h5A5A_5A5A, 4'h5, 0, 1, STAT_ADDED);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h0, 0, STAT_FOUND);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, STAT_FOUND);
        plan_row(OP_LOOKUP, 0, 0, 0, 0, 32'h8000_0000, 1, STAT_NOT_FOUND);
        plan_row(OP_CLEAR, 0, 0, 0, 0, 0, 1, STAT_CLEARED);

        foreach (plan[i])
            send_op(plan[i].op, plan[i].dest, plan[i].mask, plan[i].gw, plan[i].ifc,
                    plan[i].addr, plan[i].typed, plan[i].typed_status);

        // Random phases: build a table of related routes, then probe it
        phase = 0;
        while (beats_sent < plan.size() + RANDOM_BEATS) begin
            phase++;
            fill = (phase % 25 == 3);
            if (fill || $urandom_range(0, 3) != 0) begin
                send_op(OP_CLEAR, $urandom, $urandom, $urandom, 4'($urandom), $urandom,
                        0, STAT_CLEARED);
                gen_dest.delete();
                gen_mask.delete();
            end

            // fill phases run past capacity to hit the full case
            n_add = fill ? DEPTH - gen_dest.size() + $urandom_range(1, 3)
                         : $urandom_range(1, 10);
            base  = $urandom;
            repeat (n_add) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    len  = $urandom_range(0, ADDR_W);
                    mask = (len == 0) ? '0 : ('1 << (ADDR_W - len));
                end else if (kind == 7) begin
                    mask = '0;
                end else if (kind == 8) begin
                    mask = '1;
                end else begin
                    mask = $urandom;
                end
                // half the routes share the phase's base, so prefixes nest
                dest = $urandom_range(0, 1) ? (base ^ ($urandom >> $urandom_range(4, 31)))
                                            : $urandom;
                send_op(OP_ADD, dest, mask, $urandom, 4'($urandom), $urandom, 0, STAT_ADDED);
                if (gen_dest.size() < DEPTH) begin
                    gen_dest.push_back(dest);
                    gen_mask.push_back(mask);
                end
            end

            n_look = $urandom_range(4, 20);
            repeat (n_look) begin
                kind = $urandom_range(0, 11);
                if (kind <= 6 && gen_dest.size() != 0) begin
                    pick = $urandom_range(0, gen_dest.size() - 1);
                    addr = (gen_dest[pick] & gen_mask[pick]) | ($urandom & ~gen_mask[pick]);
                    // occasional near miss inside the prefix
                    if ($urandom_range(0, 5) == 0)
                        addr = addr ^ (32'h1 << $urandom_range(0, ADDR_W - 1));
                end else if (kind == 7) begin
                    addr = '0;
                end else if (kind == 8) begin
                    addr = base ^ ($urandom >> $urandom_range(8, 31));
                end else begin
                    addr = $urandom;
                end
                if (kind == 10)
                    send_op(OP_NOP, $urandom, $urandom, $urandom, 4'($urandom), $urandom,
                            1, STAT_NOT_FOUND);
                else if (kind == 11 && gen_dest.size() < DEPTH) begin
                    dest = $urandom;
                    mask = $urandom;
                    send_op(OP_ADD, dest, mask, $urandom, 4'($urandom), $urandom,
                            0, STAT_ADDED);
                    gen_dest.push_back(dest);
                    gen_mask.push_back(mask);
                end else
                    send_op(OP_LOOKUP, $urandom, $urandom, $urandom, 4'($urandom), addr,
                            0, STAT_FOUND);
            end
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;

        // Drain, then watch for stray beats
        while (pending_routes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d beats in, %0d results, %0d routes found, %0d lookups missed",
                 beats_in, results_seen, hits, misses);
        $display("%0d adds refused on a full table, %0d zero-address lookups, %0d mismatches",
                 full_refusals, zero_lookups, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
